FILE: design/chtc_pkg.sv
// chtc_pkg: shared types and constants for the chained hash table core
// no dependencies; imported by chained_hash_table_core
`timescale 1ns / 1ps

package chtc_pkg;

   localparam int NODE_COUNT_DEF        = 256;
   localparam int MAX_BUCKETS_LOG2_DEF  = 8;
   localparam int INITIAL_BUCKETS_LOG2_DEF = 2;
   localparam int VALUE_WIDTH_DEF       = 64;

   // fixed field widths of the item channels
   localparam int KEY_WIDTH   = 31;
   localparam int VALUE_FIELD = 64;
   localparam int TOTAL_WIDTH = 9;

   // request kinds
   localparam logic [1:0] REQ_GET    = 2'd0;
   localparam logic [1:0] REQ_PUT    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_NUM   = 2'd0;
   localparam logic [1:0] CSR_DEN   = 2'd1;
   localparam logic [1:0] CSR_SHIFT = 2'd2;

   // reset values of the registers
   localparam logic [7:0] NUM_RESET   = 8'd2;
   localparam logic [7:0] DEN_RESET   = 8'd3;
   localparam logic [1:0] SHIFT_RESET = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_G_HEAD_RD,
      ST_G_HEAD_WAIT,
      ST_G_NODE_RD,
      ST_G_NODE_WAIT,
      ST_G_FH_WAIT,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_NODE_RD,
      ST_NODE_CHK,
      ST_ALLOC_RD,
      ST_ALLOC_WAIT,
      ST_INSERT,
      ST_UNLINK,
      ST_FREE,
      ST_DONE
   } state_type;

endpackage

FILE: design/chtc_ram.sv
// chtc_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module chtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/chained_hash_table_core.sv
// chained_hash_table_core: key/value table with separate chaining in a node pool
// depends on chtc_pkg and chtc_ram
`timescale 1ns / 1ps

// One request at a time: get, put or remove of a 31-bit key, one result item
// per request. Buckets are the low bits of the key; each bucket is a chain
// of nodes in three rams (bucket heads, key/value, links), new keys go in at
// the chain head and freed nodes are reused from a free list. Before each
// put the load ratio count*den > buckets*num is checked and, if exceeded,
// the bucket count is multiplied by 2^growth_shift (capped) and every
// entry is relinked in place. Timing is set by the single read port of
// each ram: every node visited costs a read and a check, a put adds an
// allocation step, and a growth step walks every old bucket and every
// stored entry. Bucket heads need no clearing pass after reset: one
// valid flop per bucket marks the empty ones. Results wait in an output
// register, so a new item can be taken while a result is not yet collected.
module chained_hash_table_core
   import chtc_pkg::*;
#(
   parameter int NODE_COUNT           = NODE_COUNT_DEF,
   parameter int MAX_BUCKETS_LOG2     = MAX_BUCKETS_LOG2_DEF,
   parameter int INITIAL_BUCKETS_LOG2 = INITIAL_BUCKETS_LOG2_DEF,
   parameter int VALUE_WIDTH          = VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // key[30:0], value[94:31], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // hit, read_value, status, entry_total, pad
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int NADDR = $clog2(NODE_COUNT);
   localparam int NIDX  = $clog2(NODE_COUNT + 1);
   localparam int MAXL  = MAX_BUCKETS_LOG2;
   localparam int NBKT  = 1 << MAXL;
   localparam int LOGW  = $clog2(MAXL + 1);
   localparam int CMPW  = 8 + NIDX + MAXL;
   localparam int KVW   = KEY_WIDTH + VALUE_WIDTH;
   localparam int INIT_LOG2 = (INITIAL_BUCKETS_LOG2 > MAXL) ? MAXL : INITIAL_BUCKETS_LOG2;
   localparam logic [NIDX-1:0] NIL = NIDX'(NODE_COUNT);

   // control state
   state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [NIDX-1:0] free_head_ff, free_head_in;
   logic [NIDX-1:0] next_unused_ff, next_unused_in;
   logic [NIDX-1:0] count_ff, count_in;
   logic [LOGW-1:0] log2_ff, log2_in;
   logic [NBKT-1:0] hvalid_ff, hvalid_in;
   logic [7:0]      num_ff, num_in;
   logic [7:0]      den_ff, den_in;
   logic [1:0]      shift_ff, shift_in;

   // per-item working registers
   logic [1:0]             type_ff, type_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [NIDX-1:0]        cur_ff, cur_in;
   logic [NIDX-1:0]        prev_ff, prev_in;
   logic [NIDX-1:0]        next_ff, next_in;
   logic [NIDX-1:0]        head_ff, head_in;
   logic [NIDX-1:0]        node_ff, node_in;
   logic [MAXL-1:0]        bkt_ff, bkt_in;      // bucket sweep index during growth
   logic [MAXL-1:0]        nb_ff, nb_in;        // new bucket of the node being moved
   logic [MAXL-1:0]        old_last_ff, old_last_in;
   logic                   hit_ff, hit_in;
   logic                   status_ff, status_in;
   logic [VALUE_WIDTH-1:0] rd_ff, rd_in;
   logic [79:0]            rsp_data_ff, rsp_data_in;

   // ram ports
   logic            h_we, l_we, kv_we;
   logic [MAXL-1:0] h_waddr, h_raddr;
   logic [NIDX-1:0] h_wdata, h_q;
   logic [NADDR-1:0] l_waddr, l_raddr, kv_waddr, kv_raddr;
   logic [NIDX-1:0] l_wdata, l_q;
   logic [KVW-1:0]  kv_wdata, kv_q;

   // helpers
   logic [MAXL-1:0]      mask_cur, mask_new, bucket;
   logic [LOGW:0]        log2_sum;
   logic [LOGW-1:0]      log2_new;
   logic [CMPW-1:0]      lhs, rhs;
   logic                 grow_due;
   logic                 cur_nil;
   logic                 rsp_free;
   logic [KEY_WIDTH-1:0] kq_key;

   chtc_ram #(.WIDTH(NIDX), .DEPTH(NBKT)) u_heads (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_q)
   );

   chtc_ram #(.WIDTH(NIDX), .DEPTH(NODE_COUNT)) u_links (
      .clock(clock), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(l_raddr), .rd_data(l_q)
   );

   chtc_ram #(.WIDTH(KVW), .DEPTH(NODE_COUNT)) u_nodes (
      .clock(clock), .wr_en(kv_we), .wr_addr(kv_waddr), .wr_data(kv_wdata),
      .rd_addr(kv_raddr), .rd_data(kv_q)
   );

   assign mask_cur = ~({MAXL{1'b1}} << log2_ff);
   assign log2_sum = {1'b0, log2_ff} + (LOGW + 1)'(shift_ff);
   assign log2_new = (log2_sum > (LOGW + 1)'(MAXL)) ? LOGW'(MAXL) : log2_sum[LOGW-1:0];
   assign mask_new = mask_cur;   // log2_ff already holds the grown size while relinking
   assign bucket   = key_ff[MAXL-1:0] & mask_cur;
   assign lhs      = CMPW'(count_ff) * CMPW'(den_ff);
   assign rhs      = CMPW'(num_ff) << log2_ff;
   assign grow_due = (lhs > rhs) && (log2_new != log2_ff);
   assign cur_nil  = (cur_ff == NIL);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign kq_key   = kv_q[KEY_WIDTH-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_PUT) begin
                  state_in = ST_CHECK;
               end else if (req_tuser == REQ_GET || req_tuser == REQ_REMOVE) begin
                  state_in = ST_HEAD_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CHECK:       state_in = grow_due ? ST_G_HEAD_RD : ST_HEAD_RD;
         ST_G_HEAD_RD:   state_in = ST_G_HEAD_WAIT;
         ST_G_HEAD_WAIT: state_in = ST_G_NODE_RD;
         ST_G_NODE_RD: begin
            if (!cur_nil) begin
               state_in = ST_G_NODE_WAIT;
            end else if (bkt_ff == old_last_ff) begin
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_G_HEAD_RD;
            end
         end
         ST_G_NODE_WAIT: state_in = ST_G_FH_WAIT;
         ST_G_FH_WAIT:   state_in = ST_G_NODE_RD;
         ST_HEAD_RD:     state_in = ST_HEAD_WAIT;
         ST_HEAD_WAIT:   state_in = ST_NODE_RD;
         ST_NODE_RD: begin
            if (!cur_nil) begin
               state_in = ST_NODE_CHK;
            end else if (type_ff != REQ_PUT) begin
               state_in = ST_DONE;
            end else if (free_head_ff != NIL) begin
               state_in = ST_ALLOC_RD;
            end else if (next_unused_ff != NIL) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_NODE_CHK: begin
            if (kq_key != key_ff) begin
               state_in = ST_NODE_RD;
            end else if (type_ff == REQ_REMOVE) begin
               state_in = ST_UNLINK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ALLOC_RD:    state_in = ST_ALLOC_WAIT;
         ST_ALLOC_WAIT:  state_in = ST_INSERT;
         ST_INSERT:      state_in = ST_DONE;
         ST_UNLINK:      state_in = ST_FREE;
         ST_FREE:        state_in = ST_DONE;
         ST_DONE:        state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      free_head_in   = free_head_ff;
      next_unused_in = next_unused_ff;
      count_in       = count_ff;
      log2_in        = log2_ff;
      hvalid_in      = hvalid_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      shift_in       = shift_ff;
      type_in        = type_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      next_in        = next_ff;
      head_in        = head_ff;
      node_in        = node_ff;
      bkt_in         = bkt_ff;
      nb_in          = nb_ff;
      old_last_in    = old_last_ff;
      hit_in         = hit_ff;
      status_in      = status_ff;
      rd_in          = rd_ff;
      rsp_data_in    = rsp_data_ff;
      h_we     = 1'b0;
      h_waddr  = bucket;
      h_wdata  = cur_ff;
      h_raddr  = bucket;
      l_we     = 1'b0;
      l_waddr  = cur_ff[NADDR-1:0];
      l_wdata  = next_ff;
      l_raddr  = cur_ff[NADDR-1:0];
      kv_we    = 1'b0;
      kv_waddr = cur_ff[NADDR-1:0];
      kv_wdata = {val_ff, key_ff};
      kv_raddr = cur_ff[NADDR-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_NUM:   num_in   = csr_wdata;
            CSR_DEN:   den_in   = csr_wdata;
            CSR_SHIFT: shift_in = csr_wdata[1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               type_in   = req_tuser;
               key_in    = req_tdata[KEY_WIDTH-1:0];
               val_in    = req_tdata[KEY_WIDTH +: VALUE_WIDTH];
               hit_in    = 1'b0;
               status_in = 1'b0;
               rd_in     = '0;
            end
         end
         ST_CHECK: begin
            if (grow_due) begin
               log2_in     = log2_new;
               old_last_in = mask_cur;
               bkt_in      = '0;
            end
         end
         ST_G_HEAD_RD: begin
            h_raddr = bkt_ff;
         end
         ST_G_HEAD_WAIT: begin
            // old chain head taken, bucket restarts empty
            cur_in            = hvalid_ff[bkt_ff] ? h_q : NIL;
            hvalid_in[bkt_ff] = 1'b0;
         end
         ST_G_NODE_RD: begin
            if (cur_nil && bkt_ff != old_last_ff) begin
               bkt_in = bkt_ff + 1'b1;
            end
         end
         ST_G_NODE_WAIT: begin
            next_in = l_q;
            nb_in   = kq_key[MAXL-1:0] & mask_new;
            h_raddr = kq_key[MAXL-1:0] & mask_new;
         end
         ST_G_FH_WAIT: begin
            // push moved node onto its new bucket
            l_we             = 1'b1;
            l_wdata          = hvalid_ff[nb_ff] ? h_q : NIL;
            h_we             = 1'b1;
            h_waddr          = nb_ff;
            h_wdata          = cur_ff;
            hvalid_in[nb_ff] = 1'b1;
            cur_in           = next_ff;
         end
         ST_HEAD_WAIT: begin
            head_in = hvalid_ff[bucket] ? h_q : NIL;
            cur_in  = hvalid_ff[bucket] ? h_q : NIL;
            prev_in = NIL;
         end
         ST_NODE_RD: begin
            if (cur_nil && type_ff == REQ_PUT) begin
               if (free_head_ff == NIL) begin
                  if (next_unused_ff != NIL) begin
                     node_in        = next_unused_ff;
                     next_unused_in = next_unused_ff + 1'b1;
                  end else begin
                     status_in = 1'b1;
                  end
               end
            end
         end
         ST_NODE_CHK: begin
            if (kq_key == key_ff) begin
               hit_in  = 1'b1;
               node_in = cur_ff;
               next_in = l_q;
               if (type_ff == REQ_GET) begin
                  rd_in = kv_q[KEY_WIDTH +: VALUE_WIDTH];
               end else if (type_ff == REQ_PUT) begin
                  kv_we = 1'b1;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = l_q;
            end
         end
         ST_ALLOC_RD: begin
            l_raddr = free_head_ff[NADDR-1:0];
         end
         ST_ALLOC_WAIT: begin
            node_in      = free_head_ff;
            free_head_in = l_q;
         end
         ST_INSERT: begin
            kv_we            = 1'b1;
            kv_waddr         = node_ff[NADDR-1:0];
            l_we             = 1'b1;
            l_waddr          = node_ff[NADDR-1:0];
            l_wdata          = head_ff;
            h_we             = 1'b1;
            h_wdata          = node_ff;
            hvalid_in[bucket] = 1'b1;
            count_in         = count_ff + 1'b1;
         end
         ST_UNLINK: begin
            if (prev_ff == NIL) begin
               h_we              = 1'b1;
               h_wdata           = next_ff;
               hvalid_in[bucket] = 1'b1;
            end else begin
               l_we    = 1'b1;
               l_waddr = prev_ff[NADDR-1:0];
               l_wdata = next_ff;
            end
         end
         ST_FREE: begin
            l_we         = 1'b1;
            l_waddr      = node_ff[NADDR-1:0];
            l_wdata      = free_head_ff;
            free_head_in = node_ff;
            count_in     = count_ff - 1'b1;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, TOTAL_WIDTH'(count_ff), status_ff,
                               VALUE_FIELD'(rd_ff), hit_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         free_head_ff   <= NIL;
         next_unused_ff <= '0;
         count_ff       <= '0;
         log2_ff        <= LOGW'(INIT_LOG2);
         hvalid_ff      <= '0;
         num_ff         <= NUM_RESET;
         den_ff         <= DEN_RESET;
         shift_ff       <= SHIFT_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         free_head_ff   <= free_head_in;
         next_unused_ff <= next_unused_in;
         count_ff       <= count_in;
         log2_ff        <= log2_in;
         hvalid_ff      <= hvalid_in;
         num_ff         <= num_in;
         den_ff         <= den_in;
         shift_ff       <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      next_ff     <= next_in;
      head_ff     <= head_in;
      node_ff     <= node_in;
      bkt_ff      <= bkt_in;
      nb_ff       <= nb_in;
      old_last_ff <= old_last_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted item always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted item left the sequencer idle");

   // entry count and pool fill stay within the pool
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL && next_unused_ff <= NIL)
      else $error("entry count or pool fill out of range");

   // a dropped insert only happens with the pool in full use
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && status_ff |-> count_ff == NIL)
      else $error("pool full reported with free nodes left");

   // a finished item is handed to the output register
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_free |=> rsp_valid_ff)
      else $error("result lost on completion");

endmodule
